[hdl/hec_pkg.sv]
package hec_pkg;

   localparam int WORD_BITS             = 63;
   localparam int SYN_BITS              = 6;
   localparam int DEFAULT_MAX_CODE_BITS = 63;
   localparam int DATA_BITS_LIMIT       = 57;
   localparam logic [SYN_BITS-1:0] DATA_BITS_RESET = 6'd4;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_CHECK  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_CORRECTED = 2'd1,
      STATUS_BEYOND    = 2'd2
   } status_type;

   typedef struct packed {
      op_type               op;
      logic [WORD_BITS-1:0] word;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] codeword;
      logic [SYN_BITS-1:0]  syndrome;
      status_type           status;
   } rsp_type;

   // least r with 2^r >= d + r + 1
   function automatic logic [2:0] parity_count(input logic [SYN_BITS-1:0] d);
      logic [2:0] r;
      r = 3'd6;
      for (int k = 6; k >= 1; k--) begin
         if ((8'd1 << k) >= (8'(d) + 8'(k) + 8'd1)) begin
            r = 3'(k);
         end
      end
      return r;
   endfunction

   function automatic logic [SYN_BITS-1:0] max_data_bits(input int max_code);
      logic [SYN_BITS-1:0] best;
      best = 6'd1;
      for (int d = 1; d <= DATA_BITS_LIMIT; d++) begin
         if (d + int'(parity_count(6'(d))) <= max_code) begin
            best = 6'(d);
         end
      end
      return best;
   endfunction

   function automatic logic [SYN_BITS-1:0] eff_data_bits(input logic [SYN_BITS-1:0] raw,
                                                         input logic [SYN_BITS-1:0] max_d);
      logic [SYN_BITS-1:0] d;
      if (raw == 6'd0) begin
         d = 6'd1;
      end else if (raw > max_d) begin
         d = max_d;
      end else begin
         d = raw;
      end
      return d;
   endfunction

   function automatic logic [SYN_BITS-1:0] code_length(input logic [SYN_BITS-1:0] d);
      return d + 6'(parity_count(d));
   endfunction

   // positions whose index has bit i set
   function automatic logic [WORD_BITS-1:0] syn_mask(input int i);
      logic [WORD_BITS-1:0] m;
      m = '0;
      for (int p = 1; p <= WORD_BITS; p++) begin
         if (((p >> i) & 1) == 1) begin
            m[p-1] = 1'b1;
         end
      end
      return m;
   endfunction

   function automatic logic [SYN_BITS-1:0] syndrome_of(input logic [WORD_BITS-1:0] w);
      logic [SYN_BITS-1:0] s;
      for (int i = 0; i < SYN_BITS; i++) begin
         s[i] = ^(w & syn_mask(i));
      end
      return s;
   endfunction

   function automatic bit is_pow2(input int v);
      return (v != 0) && ((v & (v - 1)) == 0);
   endfunction

   // data bit carried at a non-power-of-two position
   function automatic int data_index(input int p);
      return p - $clog2(p + 1) - 1;
   endfunction

endpackage

[hdl/hamming_encode_correct_core.sv]
// Even-parity Hamming encoder and single-error corrector. One item can be
// started in every cycle (busy stays low) and its result appears on the rsp
// ports, held for exactly one cycle with rsp_strobe high, after passing the
// request register, the parity trees and the result register. The receiver
// cannot hold results off, so it must take every transfer as it is strobed.
// The data-bit count is written through the csr port; the user must write
// it only while no item is in flight, which the block does not enforce. Zero
// reads as one and values whose code would exceed MAX_CODE_BITS are clamped.
module hamming_encode_correct_core #(
   parameter int MAX_CODE_BITS = hec_pkg::DEFAULT_MAX_CODE_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  hec_pkg::req_type           req_payload,
   output logic                       rsp_strobe,
   output hec_pkg::rsp_type           rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [hec_pkg::SYN_BITS-1:0] csr_write_data
);

   import hec_pkg::*;

   localparam logic [SYN_BITS-1:0] MAX_D   = max_data_bits(MAX_CODE_BITS);
   localparam logic [SYN_BITS-1:0] RESET_D = eff_data_bits(DATA_BITS_RESET, MAX_D);

   logic [SYN_BITS-1:0] d_ff, d_in;
   logic [SYN_BITS-1:0] n_ff, n_in;
   logic                req_valid_ff;
   req_type             req_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;

   logic [WORD_BITS-1:0] n_mask;
   logic [WORD_BITS-1:0] d_mask;
   logic [WORD_BITS-1:0] data;
   logic [WORD_BITS-1:0] scattered;
   logic [WORD_BITS-1:0] received;
   logic [SYN_BITS-1:0]  enc_syn;
   logic [SYN_BITS-1:0]  chk_syn;

   assign busy = 1'b0;

   assign d_in = eff_data_bits(csr_write_data, MAX_D);
   assign n_in = code_length(d_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff <= RESET_D;
         n_ff <= code_length(RESET_D);
      end else if (csr_write_enable) begin
         d_ff <= d_in;
         n_ff <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   assign n_mask = (WORD_BITS'(1) << n_ff) - WORD_BITS'(1);
   assign d_mask = (WORD_BITS'(1) << d_ff) - WORD_BITS'(1);

   always_comb begin
      data      = req_ff.word & d_mask;
      scattered = '0;
      for (int p = 1; p <= WORD_BITS; p++) begin
         if (!is_pow2(p)) begin
            scattered[p-1] = data[data_index(p)];
         end
      end
      enc_syn  = syndrome_of(scattered);
      received = req_ff.word & n_mask;
      chk_syn  = syndrome_of(received);

      rsp_in.codeword = '0;
      rsp_in.syndrome = '0;
      rsp_in.status   = STATUS_OK;
      case (req_ff.op)
         OP_ENCODE: begin
            rsp_in.codeword = scattered;
            for (int i = 0; i < SYN_BITS; i++) begin
               rsp_in.codeword[(1 << i) - 1] = enc_syn[i];
            end
            rsp_in.codeword = rsp_in.codeword & n_mask;
         end
         OP_CHECK: begin
            rsp_in.codeword = received;
            rsp_in.syndrome = chk_syn;
            if (chk_syn != '0) begin
               if (chk_syn <= n_ff) begin
                  rsp_in.codeword = received ^ (WORD_BITS'(1) << (chk_syn - 6'd1));
                  rsp_in.status   = STATUS_CORRECTED;
               end else begin
                  rsp_in.status   = STATUS_BEYOND;
               end
            end
         end
         default: begin
            rsp_in.codeword = '0;
         end
      endcase
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // every started transfer comes out with rsp_strobe after the request and result registers
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("started transfer did not produce a result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_payload.codeword & ~n_mask) == '0))
      else $error("codeword bits beyond code length");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status == STATUS_BEYOND) |-> (rsp_payload.syndrome > n_ff))
      else $error("beyond-length status with in-range syndrome");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status == STATUS_CORRECTED) |->
      (rsp_payload.syndrome != '0 && rsp_payload.syndrome <= n_ff))
      else $error("correction reported without valid syndrome");

endmodule
